FILE: hdl/substring_search_engine_assert.svh
// ----------------------------------------------------------------------------
// substring_search_engine_assert.svh
// Assertion macros used by the substring search engine checker.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_SEARCH_ENGINE_ASSERT_SVH
`define SUBSTRING_SEARCH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Constants, codes and shared types of the substring search engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int OFFSET_BITS = 16;

  localparam int PC_W  = $clog2(PATTERN_MAX + 1);   // pattern count / length
  localparam int TC_W  = OFFSET_BITS + 1;           // text count, holds limit
  localparam int CFG_IDX_W = 2;

  localparam logic [TC_W-1:0] POS_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

  typedef enum logic [1:0] {
    MODE_PATTERN = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_FINISH  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_FOUND       = 2'd0,
    STAT_NOT_FOUND   = 2'd1,
    STAT_PAT_LONG    = 2'd2,
    STAT_REGION_LONG = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BACKWARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE     = 2'd1;

  // Per-beat control broadcast along the cell row
  typedef struct packed {
    logic shift_pat;
    logic shift_text;
    logic clear;
    logic fold;
  } cell_ctl_t;

  // ASCII a..z onto A..Z when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= 8'h61) && (c <= 8'h7A)) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: hdl/sse_cell.sv
// ----------------------------------------------------------------------------
// sse_cell
// One window cell: a pattern byte, its valid bit and a text byte, compared.
// ----------------------------------------------------------------------------
module sse_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sse_pkg::cell_ctl_t  ctl,
  input  logic [7:0]          pat_in,
  input  logic                pv_in,
  input  logic [7:0]          text_in,
  output logic [7:0]          pat_out,
  output logic                pv_out,
  output logic [7:0]          text_out,
  output logic                hit
);
  import sse_pkg::*;

  logic [7:0] pat_r;
  logic [7:0] text_r;
  logic       pv_r;
  logic       pv_nxt;

  always_comb begin
    pv_nxt = pv_r;
    if (ctl.clear) begin
      pv_nxt = 1'b0;
    end else if (ctl.shift_pat) begin
      pv_nxt = pv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_pat) begin
      pat_r <= pat_in;
    end
    if (ctl.shift_text) begin
      text_r <= text_in;
    end
  end

  // compare against the byte this cell is about to take
  assign hit      = !pv_r || (fold_byte(pat_r, ctl.fold) == fold_byte(text_in, ctl.fold));
  assign pat_out  = pat_r;
  assign pv_out   = pv_r;
  assign text_out = text_r;

endmodule

FILE: hdl/sse_chain.sv
// ----------------------------------------------------------------------------
// sse_chain
// Row of window cells; reports whether every loaded pattern byte matches.
// ----------------------------------------------------------------------------
module sse_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  sse_pkg::cell_ctl_t  ctl,
  input  logic [7:0]          byte_in,
  output logic                all_hit,
  output logic                full
);
  import sse_pkg::*;

  logic [7:0]       pat_c  [PATTERN_MAX+1];
  logic [7:0]       text_c [PATTERN_MAX+1];
  logic             pv_c   [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;

  assign pat_c[0]  = byte_in;
  assign text_c[0] = byte_in;
  assign pv_c[0]   = 1'b1;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    sse_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .pat_in   (pat_c[g]),
      .pv_in    (pv_c[g]),
      .text_in  (text_c[g]),
      .pat_out  (pat_c[g+1]),
      .pv_out   (pv_c[g+1]),
      .text_out (text_c[g+1]),
      .hit      (hits[g])
    );
  end

  assign all_hit = &hits;
  assign full    = pv_c[PATTERN_MAX];  // last cell loaded: store is full

endmodule

FILE: hdl/substring_search_engine.sv
// ----------------------------------------------------------------------------
// substring_search_engine
// Streamed substring search with optional ASCII case folding.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | in_mode, in_data_byte
//  out_    | out       | out_valid/out_stall| out_status, out_match_offset,
//          |           |                    | out_match_length
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One beat per cycle while in_stall is low: the window compare across the cell
// row completes in the same cycle that the text byte lands.
// A finish beat loads the result register; the result appears the next cycle.
// in_stall rises only while a result is held and out_stall is high.
// Reset (rst_n low, synchronous) clears counts, flags and cell valid bits;
// the pattern and text bytes in the cells are not reset.
// ----------------------------------------------------------------------------
module substring_search_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // item input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [7:0]                        in_data_byte,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [sse_pkg::OFFSET_BITS-1:0]   out_match_offset,
  output logic [sse_pkg::PC_W-1:0]          out_match_length,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                              cfg_wdata
);
  import sse_pkg::*;

  // config registers
  logic backward_r, backward_nxt;
  logic fold_r,     fold_nxt;

  // search state
  logic [PC_W-1:0]        pc_r,    pc_nxt;
  logic                   pov_r,   pov_nxt;
  logic [TC_W-1:0]        tc_r,    tc_nxt;
  logic                   found_r, found_nxt;
  logic [OFFSET_BITS-1:0] pos_r,   pos_nxt;

  // result register
  logic                   ovalid_r,  ovalid_nxt;
  logic [1:0]             ostat_r,   ostat_nxt;
  logic [OFFSET_BITS-1:0] ooff_r,    ooff_nxt;
  logic [PC_W-1:0]        olen_r,    olen_nxt;

  logic       acc, is_pat, is_text, is_fin;
  logic       text_ok;
  logic       chain_hit, chain_full, match_hit;
  logic [TC_W-1:0] tc_inc, pc_ext;
  cell_ctl_t  ctl;

  // input is held off only when a finished result cannot leave
  assign in_stall  = ovalid_r && out_stall;
  assign cfg_ready = 1'b1;

  assign acc     = in_valid && !in_stall;
  assign is_pat  = acc && (in_mode == MODE_PATTERN);
  assign is_text = acc && (in_mode == MODE_TEXT);
  assign is_fin  = acc && (in_mode == MODE_FINISH);

  // region counter saturates at the limit; further text is dropped
  assign text_ok = (tc_r < POS_LIMIT);
  assign tc_inc  = tc_r + TC_W'(1);
  assign pc_ext  = TC_W'(pc_r);

  always_comb begin
    ctl.shift_pat  = is_pat && (tc_r == '0) && !chain_full;
    ctl.shift_text = is_text && text_ok;
    ctl.clear      = is_fin;
    ctl.fold       = fold_r;
  end

  sse_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .byte_in (in_data_byte),
    .all_hit (chain_hit),
    .full    (chain_full)
  );

  // window end reached the pattern length and all loaded cells agree
  assign match_hit = ctl.shift_text && (pc_r != '0) && (tc_inc >= pc_ext) &&
                     (backward_r || !found_r) && chain_hit;

  // config writes
  always_comb begin
    backward_nxt = backward_r;
    fold_nxt     = fold_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEARCH_BACKWARD: backward_nxt = cfg_wdata;
        CFG_IGNORE_CASE:     fold_nxt     = cfg_wdata;
        default:             ;
      endcase
    end
  end

  // search state update
  always_comb begin
    pc_nxt    = pc_r;
    pov_nxt   = pov_r;
    tc_nxt    = tc_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    if (is_fin) begin
      pc_nxt    = '0;
      pov_nxt   = 1'b0;
      tc_nxt    = '0;
      found_nxt = 1'b0;
      pos_nxt   = '0;
    end else begin
      if (ctl.shift_pat) begin
        pc_nxt = pc_r + PC_W'(1);
      end else if (is_pat && (tc_r == '0)) begin
        pov_nxt = 1'b1;              // store already full
      end
      if (ctl.shift_text) begin
        tc_nxt = tc_inc;
      end
      if (match_hit) begin
        found_nxt = 1'b1;
        pos_nxt   = OFFSET_BITS'(tc_inc - pc_ext);
      end
    end
  end

  // result register: loads on finish, drains when taken
  always_comb begin
    ovalid_nxt = ovalid_r;
    ostat_nxt  = ostat_r;
    ooff_nxt   = ooff_r;
    olen_nxt   = olen_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (is_fin) begin
      ovalid_nxt = 1'b1;
      ooff_nxt   = '0;
      olen_nxt   = '0;
      if (pov_r) begin
        ostat_nxt = STAT_PAT_LONG;
      end else if (!text_ok) begin
        ostat_nxt = STAT_REGION_LONG;
      end else if (pc_r == '0) begin
        // empty pattern: region start forward, region end backward
        ostat_nxt = STAT_FOUND;
        ooff_nxt  = backward_r ? tc_r[OFFSET_BITS-1:0] : '0;
      end else if (found_r) begin
        ostat_nxt = STAT_FOUND;
        ooff_nxt  = pos_r;
        olen_nxt  = pc_r;
      end else begin
        ostat_nxt = STAT_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backward_r <= 1'b0;
      fold_r     <= 1'b0;
      pc_r       <= '0;
      pov_r      <= 1'b0;
      tc_r       <= '0;
      found_r    <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      backward_r <= backward_nxt;
      fold_r     <= fold_nxt;
      pc_r       <= pc_nxt;
      pov_r      <= pov_nxt;
      tc_r       <= tc_nxt;
      found_r    <= found_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    ostat_r <= ostat_nxt;
    ooff_r  <= ooff_nxt;
    olen_r  <= olen_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_status       = ostat_r;
  assign out_match_offset = ooff_r;
  assign out_match_length = olen_r;

endmodule

FILE: hdl/sse_checker.sv
// ----------------------------------------------------------------------------
// sse_checker
// Port-level checks of the substring search engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "substring_search_engine_assert.svh"

module sse_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [1:0]                      in_mode,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_status,
  input logic [sse_pkg::OFFSET_BITS-1:0] out_match_offset,
  input logic [sse_pkg::PC_W-1:0]        out_match_length
);
  import sse_pkg::*;

  logic                          fin_acc;
  logic                          out_held;
  logic                          out_fail;
  logic                          fields_zero;
  logic [OFFSET_BITS+PC_W+1:0]   out_payload;

  assign fin_acc     = in_valid && !in_stall && (in_mode == MODE_FINISH);
  assign out_held    = out_valid && out_stall;
  assign out_fail    = out_valid && (out_status != STAT_FOUND);
  assign fields_zero = (out_match_offset == '0) && (out_match_length == '0);
  assign out_payload = {out_status, out_match_offset, out_match_length};

  // a held result keeps its payload
  `SSE_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_payload), "held result changed")

  // every finish beat shows a result on the next cycle
  `SSE_ASSERT_NXT(a_fin_result, fin_acc, out_valid, "finish beat gave no result")

  // back-pressure only while a result is held
  `SSE_ASSERT_IMP(a_stall_cause, in_stall, out_held, "input stalled without cause")

  // failure codes carry no offset or length
  `SSE_ASSERT_IMP(a_fail_zero, out_fail, fields_zero, "failed search with nonzero fields")

  // reported length never exceeds the pattern store
  `SSE_ASSERT_IMP(a_len_max, out_valid, out_match_length <= PC_W'(PATTERN_MAX), "length beyond store")

endmodule

bind substring_search_engine sse_checker u_sse_checker (.*);

FILE: tb/sv/sse_tb_pkg.sv
// ----------------------------------------------------------------------------
// sse_tb_pkg
// Scoreboard of the substring search engine bench: an independent search
// predictor fed with accepted input beats, and an in-order result check.
// ----------------------------------------------------------------------------
package sse_tb_pkg;

  import sse_pkg::*;

  // mode code with no meaning; the block drops such beats
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef logic [7:0] byte_queue_t[$];

  class search_scoreboard;

    typedef struct {
      logic [1:0]             status;
      logic [OFFSET_BITS-1:0] offset;
      logic [PC_W-1:0]        length;
    } search_result_t;

    search_result_t expected_q[$];
    int unsigned    errors;

    // register copies
    bit backward;
    bit nocase;

    // search state
    logic [7:0]  pat_bytes [PATTERN_MAX];
    int unsigned pat_len;
    bit          pat_overflow;
    logic [7:0]  window [PATTERN_MAX];
    int unsigned text_len;
    bit          hit;
    int unsigned hit_at;

    function new();
      errors   = 0;
      backward = 1'b0;
      nocase   = 1'b0;
      restart();
    endfunction

    function void restart();
      pat_len      = 0;
      pat_overflow = 1'b0;
      text_len     = 0;
      hit          = 1'b0;
      hit_at       = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
      if (idx == CFG_SEARCH_BACKWARD) begin
        backward = val;
      end else if (idx == CFG_IGNORE_CASE) begin
        nocase = val;
      end
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      if (nocase && c >= 8'h61 && c <= 8'h7a) return c - 8'h20;
      return c;
    endfunction

    // window slots wrap; the newest pat_len text bytes line up with the pattern
    function bit window_hit();
      int unsigned start_at;
      start_at = text_len - pat_len;
      for (int unsigned i = 0; i < pat_len; i++) begin
        if (upcase(pat_bytes[i]) != upcase(window[(start_at + i) % PATTERN_MAX])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic [1:0] mode, logic [7:0] data);
      search_result_t r;
      case (mode)
        MODE_PATTERN: begin
          // pattern beats count only before the first text beat
          if (text_len == 0) begin
            if (pat_len < PATTERN_MAX) begin
              pat_bytes[pat_len] = data;
              pat_len++;
            end else begin
              pat_overflow = 1'b1;
            end
          end
        end
        MODE_TEXT: begin
          if (text_len < POS_LIMIT) begin
            window[text_len % PATTERN_MAX] = data;
            text_len++;
            if (pat_len > 0 && text_len >= pat_len && (backward || !hit) && window_hit()) begin
              hit    = 1'b1;
              hit_at = text_len - pat_len;
            end
          end
        end
        MODE_FINISH: begin
          r.offset = '0;
          r.length = '0;
          if (pat_overflow) begin
            r.status = STAT_PAT_LONG;
          end else if (text_len >= POS_LIMIT) begin
            r.status = STAT_REGION_LONG;
          end else if (pat_len == 0) begin
            r.status = STAT_FOUND;
            if (backward) r.offset = OFFSET_BITS'(text_len);
          end else if (hit) begin
            r.status = STAT_FOUND;
            r.offset = OFFSET_BITS'(hit_at);
            r.length = PC_W'(pat_len);
          end else begin
            r.status = STAT_NOT_FOUND;
          end
          expected_q.push_back(r);
          restart();
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_result(logic [1:0] status, logic [OFFSET_BITS-1:0] offset,
                               logic [PC_W-1:0] length);
      search_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d offset %0d length %0d",
                 $time, status, offset, length);
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", e.status, status);
      compare_field("match_offset", e.offset, offset);
      compare_field("match_length", e.length, length);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

  endclass

endpackage

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for substring_search_engine. Streams pattern, text and
// finish beats with random sender gaps and random result back-pressure,
// predicts each search report and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sse_pkg::*;
  import sse_tb_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int ITEM_TARGET    = 650;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 4;     // finish -> result comes the next cycle
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_mode = '0;
  logic [7:0]             in_data_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_status;
  logic [OFFSET_BITS-1:0] out_match_offset;
  logic [PC_W-1:0]        out_match_length;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic                   cfg_wdata = 1'b0;

  // idle percentages of each side, set per phase
  int snd_idle = 0;
  int rcv_idle = 0;

  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   items_sent = 0;

  search_scoreboard sb;

  substring_search_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_match_offset (out_match_offset),
    .out_match_length (out_match_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Result side: random stall, or a long hold-off once hold_req pulses.
  // The hold is counted here so the sender keeps pushing beats meanwhile.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= hold_req || hold_left > 1 || ($urandom_range(99) < rcv_idle);
  end

  // Monitor: results checked first, then the input beat fed to the predictor.
  // A finish beat's result cannot land in the same cycle, so order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_status, out_match_offset, out_match_length);
      end
      if (in_valid && !in_stall) begin
        sb.note_item(in_mode, in_data_byte);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // One input beat; random gaps ahead of it, valid held until accepted.
  // Valid is left high on return so back-to-back beats need no dip.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // Sender pause: nothing offered until every expected report has arrived.
  // The first edge lets the monitor log a finish accepted just before.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Registers only change with the block idle
  task automatic apply_setting(input bit bwd, input bit nc);
    wait_drained();
    write_reg(CFG_SEARCH_BACKWARD, bwd);
    write_reg(CFG_IGNORE_CASE, nc);
    cfg_valid <= 1'b0;
  endtask

  function automatic byte_queue_t to_bytes(input string s);
    byte_queue_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // 0: any byte; 1: tiny alphabet so matches are common;
  // other: bytes near the ASCII letter range edges, and high-bit bytes
  function automatic logic [7:0] pick_byte(input int alpha);
    logic [7:0] c;
    case (alpha)
      0: c = 8'($urandom_range(255));
      1: begin
        case ($urandom_range(3))
          0: c = "a";
          1: c = "A";
          2: c = "b";
          default: c = "B";
        endcase
      end
      default: begin
        case ($urandom_range(7))
          0: c = 8'h40;
          1: c = 8'h5b;
          2: c = 8'h60;
          3: c = 8'h7b;
          4: c = "z";
          5: c = "Z";
          6: c = 8'he1;
          default: c = 8'hc1;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1)) return c ^ 8'h20;
    return c;
  endfunction

  // Pattern beats, text beats with an optional stray beat at stray_at
  // (unused mode, or an extra pattern beat), then the finish beat.
  task automatic run_search(input byte_queue_t pat, input byte_queue_t txt,
                            input int stray_at, input logic [1:0] stray_mode);
    foreach (pat[i]) send_item(MODE_PATTERN, pat[i]);
    for (int i = 0; i <= txt.size(); i++) begin
      if (i == stray_at) send_item(stray_mode, 8'($urandom_range(255)));
      if (i < txt.size()) send_item(MODE_TEXT, txt[i]);
    end
    send_item(MODE_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic random_search(input int max_text);
    byte_queue_t pat;
    byte_queue_t txt;
    int          plen;
    int          tlen;
    int          alpha;
    int          roll;
    int          at;
    int          stray_at;
    logic [1:0]  stray_mode;
    roll = $urandom_range(99);
    case ($urandom_range(9))
      0, 1: alpha = 0;
      2, 3: alpha = 2;
      default: alpha = 1;
    endcase
    if (roll < 4) begin
      // around the pattern store depth, overflow included
      plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 3);
      tlen = $urandom_range(0, 80);
    end else if (roll < 9) begin
      // text up to well past the window depth so slots wrap
      plen = $urandom_range(0, 4);
      tlen = $urandom_range(PATTERN_MAX - 4, 2 * PATTERN_MAX + 12);
    end else begin
      plen = $urandom_range(0, 4);
      tlen = $urandom_range(0, max_text);
    end
    for (int i = 0; i < plen; i++) pat.push_back(pick_byte(alpha));
    for (int i = 0; i < tlen; i++) txt.push_back(pick_byte(alpha));
    // plant copies of the pattern, possibly more than one for first/last
    if (plen > 0 && plen <= tlen) begin
      repeat ($urandom_range(0, 2)) begin
        at = $urandom_range(0, tlen - plen);
        for (int i = 0; i < plen; i++) txt[at + i] = flip_case(pat[i]);
      end
    end
    stray_at   = ($urandom_range(7) == 0) ? int'($urandom_range(0, tlen)) : -1;
    stray_mode = $urandom_range(1) ? MODE_UNUSED : MODE_PATTERN;
    run_search(pat, txt, stray_at, stray_mode);
  endtask

  // Receiver holds off for a long stretch while the sender keeps going,
  // so a result backs up and the input stalls.
  task automatic hold_off_burst();
    in_valid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (6) random_search(4);
  endtask

  initial begin
    byte_queue_t pat;
    byte_queue_t txt;
    logic [1:0]  setting;
    int          searches;
    int          goal;

    sb = new();
    setting  = 2'd0;
    searches = 0;
    snd_idle = 18;
    rcv_idle = 80;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed beats, registers at their reset values first ---
    // empty search straight out of reset: found at offset 0, length 0
    run_search(to_bytes(""), to_bytes(""), -1, MODE_UNUSED);
    // all-ones and all-zero bytes, with an unused-mode beat mid text
    pat.push_back(8'hff);
    pat.push_back(8'h00);
    for (int i = 0; i < 5; i++) txt.push_back((i % 2) ? 8'hff : 8'h00);
    run_search(pat, txt, 2, MODE_UNUSED);
    // pattern longer than the region: nothing to find
    run_search(to_bytes("ab"), to_bytes("a"), -1, MODE_UNUSED);
    // backward with case folding; late pattern beat must be dropped
    apply_setting(1'b1, 1'b1);
    run_search(to_bytes("aB"), to_bytes("ABxab"), 1, MODE_PATTERN);
    // empty pattern going backward reports the region length
    run_search(to_bytes(""), to_bytes("xyz"), -1, MODE_UNUSED);

    // --- random searches over three idling phases ---
    items_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle = 18;
          rcv_idle = 80;
        end
        1: begin
          snd_idle = 80;
          rcv_idle = 18;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      goal = ITEM_TARGET * (phase + 1) / 3;
      while (items_sent < goal) begin
        // walk all four register combinations, a few searches each
        if (searches % 6 == 0) begin
          apply_setting(setting[0], setting[1]);
          setting++;
        end
        random_search(10);
        searches++;
        if (searches == 3) hold_off_burst();
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
